// File: rtl/ktc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ktc_pkg: shared types and constants for the keyed table
// Table geometry, command and status codes, and the slot memory request.
// ----------------------------------------------------------------------------
package ktc_pkg;

   localparam int ENTRIES      = 16;
   localparam int PAYLOAD_BITS = 64;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   typedef enum logic [1:0] {
      CMD_INSERT  = 2'd0,
      CMD_LOOKUP  = 2'd1,
      CMD_DELETE  = 2'd2,
      CMD_COMPACT = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_DUPLICATE = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      logic                    wr_en;
      logic [IDX_W-1:0]        wr_addr;
      logic [31:0]             wr_key;
      logic [PAYLOAD_BITS-1:0] wr_payload;
      logic [IDX_W-1:0]        rd_addr;
   } mem_req_type;

endpackage

// File: rtl/ktc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ktc_if: request and response channels of the keyed table
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ktc_req_if;
   logic                 valid;
   logic                 ready;
   ktc_pkg::cmd_type     cmd;
   logic signed [31:0]   key;
   logic [63:0]          payload;

   modport source (output valid, output cmd, output key, output payload, input ready);
   modport sink   (input valid, input cmd, input key, input payload, output ready);
endinterface

interface ktc_rsp_if;
   logic                 valid;
   logic                 ready;
   ktc_pkg::status_type  status;
   logic [63:0]          found_payload;
   logic [4:0]           fill_level;

   modport source (output valid, output status, output found_payload,
                   output fill_level, input ready);
   modport sink   (input valid, input status, input found_payload,
                   input fill_level, output ready);
endinterface

// File: rtl/ktc_slot_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ktc_slot_mem: key and payload storage of the table slots
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ktc_slot_mem (
   input  logic                                clock,
   input  ktc_pkg::mem_req_type                mem_req,
   output logic [31:0]                         rd_key,
   output logic [ktc_pkg::PAYLOAD_BITS-1:0]    rd_payload
);

   logic [31:0]                      key_mem [ktc_pkg::ENTRIES];
   logic [ktc_pkg::PAYLOAD_BITS-1:0] pl_mem  [ktc_pkg::ENTRIES];
   logic [31:0]                      rd_key_ff;
   logic [ktc_pkg::PAYLOAD_BITS-1:0] rd_payload_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         key_mem[mem_req.wr_addr] <= mem_req.wr_key;
         pl_mem[mem_req.wr_addr]  <= mem_req.wr_payload;
      end
   end

   always_ff @(posedge clock) begin
      rd_key_ff     <= key_mem[mem_req.rd_addr];
      rd_payload_ff <= pl_mem[mem_req.rd_addr];
   end

   assign rd_key     = rd_key_ff;
   assign rd_payload = rd_payload_ff;

endmodule

// File: rtl/ktc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ktc_ctrl: command sequencer of the keyed table
// Walks the used slots once per pass for a key search or a compaction, with
// one slot compare or move per cycle, and holds the busy marks and fill count.
// ----------------------------------------------------------------------------
module ktc_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   ktc_req_if.sink                             req_if,
   ktc_rsp_if.source                           rsp_if,
   output ktc_pkg::mem_req_type                mem_req,
   input  logic [31:0]                         rd_key,
   input  logic [ktc_pkg::PAYLOAD_BITS-1:0]    rd_payload
);

   localparam int IDX_W = ktc_pkg::IDX_W;
   localparam int CNT_W = ktc_pkg::CNT_W;
   localparam int PB    = ktc_pkg::PAYLOAD_BITS;
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ktc_pkg::ENTRIES);

   typedef enum logic [3:0] {
      S_IDLE    = 4'b0001,
      S_COMPACT = 4'b0010,
      S_SEARCH  = 4'b0100,
      S_RESP    = 4'b1000
   } state_type;

   state_type                    state_ff, state_in;
   ktc_pkg::cmd_type             cmd_ff, cmd_in;
   logic [31:0]                  key_ff, key_in;
   logic [PB-1:0]                pl_ff, pl_in;
   logic [ktc_pkg::ENTRIES-1:0]  busy_ff, busy_in;
   logic [CNT_W-1:0]             used_ff, used_in;
   logic [CNT_W-1:0]             scan_ff, scan_in;
   logic                         pend_ff, pend_in;
   logic [IDX_W-1:0]             pend_idx_ff, pend_idx_in;
   logic [CNT_W-1:0]             wr_ptr_ff, wr_ptr_in;
   ktc_pkg::status_type          status_ff, status_in;
   logic [63:0]                  found_ff, found_in;

   logic issue;
   logic hit;
   logic walk_done;

   // a read is issued for every slot below the fill position
   assign issue     = (scan_ff < used_ff);
   assign hit       = pend_ff && busy_ff[pend_idx_ff] && (rd_key == key_ff);
   assign walk_done = !issue && !pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         busy_ff   <= '0;
         used_ff   <= '0;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         busy_ff   <= busy_in;
         used_ff   <= used_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      pl_ff       <= pl_in;
      scan_ff     <= scan_in;
      pend_idx_ff <= pend_idx_in;
      wr_ptr_ff   <= wr_ptr_in;
      status_ff   <= status_in;
      found_ff    <= found_in;
   end

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      key_in      = key_ff;
      pl_in       = pl_ff;
      busy_in     = busy_ff;
      used_in     = used_ff;
      scan_in     = scan_ff;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      wr_ptr_in   = wr_ptr_ff;
      status_in   = status_ff;
      found_in    = found_ff;

      mem_req.wr_en      = 1'b0;
      mem_req.wr_addr    = wr_ptr_ff[IDX_W-1:0];
      mem_req.wr_key     = rd_key;
      mem_req.wr_payload = rd_payload;
      mem_req.rd_addr    = scan_ff[IDX_W-1:0];

      case (state_ff)
         S_IDLE: begin
            pend_in   = 1'b0;
            if (req_if.valid) begin
               cmd_in    = req_if.cmd;
               key_in    = req_if.key;
               pl_in     = req_if.payload[PB-1:0];
               scan_in   = '0;
               wr_ptr_in = '0;
               status_in = ktc_pkg::ST_OK;
               found_in  = '0;
               case (req_if.cmd)
                  ktc_pkg::CMD_INSERT:  state_in = (used_ff >= FULL_CNT) ? S_COMPACT
                                                                         : S_SEARCH;
                  ktc_pkg::CMD_COMPACT: state_in = S_COMPACT;
                  default:              state_in = S_SEARCH;
               endcase
            end
         end

         S_SEARCH: begin
            pend_in     = issue;
            pend_idx_in = scan_ff[IDX_W-1:0];
            if (issue) begin
               scan_in = scan_ff + 1'b1;
            end
            if (hit) begin
               state_in = S_RESP;
               pend_in  = 1'b0;
               case (cmd_ff)
                  ktc_pkg::CMD_INSERT: status_in = ktc_pkg::ST_DUPLICATE;
                  ktc_pkg::CMD_LOOKUP: found_in  = 64'(rd_payload);
                  ktc_pkg::CMD_DELETE: busy_in[pend_idx_ff] = 1'b0;
                  default:             status_in = ktc_pkg::ST_OK;
               endcase
            end else if (walk_done) begin
               state_in = S_RESP;
               if (cmd_ff == ktc_pkg::CMD_INSERT) begin
                  // no duplicate: append at the fill position
                  mem_req.wr_en      = 1'b1;
                  mem_req.wr_addr    = used_ff[IDX_W-1:0];
                  mem_req.wr_key     = key_ff;
                  mem_req.wr_payload = pl_ff;
                  busy_in[used_ff[IDX_W-1:0]] = 1'b1;
                  used_in = used_ff + 1'b1;
               end else begin
                  status_in = ktc_pkg::ST_NOT_FOUND;
               end
            end
         end

         S_COMPACT: begin
            pend_in     = issue;
            pend_idx_in = scan_ff[IDX_W-1:0];
            if (issue) begin
               scan_in = scan_ff + 1'b1;
            end
            // busy slot read last cycle moves down to the write pointer
            if (pend_ff && busy_ff[pend_idx_ff]) begin
               mem_req.wr_en = 1'b1;
               wr_ptr_in     = wr_ptr_ff + 1'b1;
            end
            if (walk_done) begin
               for (int e = 0; e < ktc_pkg::ENTRIES; e++) begin
                  busy_in[e] = (CNT_W'(e) < wr_ptr_ff);
               end
               used_in = wr_ptr_ff;
               scan_in = '0;
               if (cmd_ff == ktc_pkg::CMD_INSERT) begin
                  if (wr_ptr_ff >= FULL_CNT) begin
                     status_in = ktc_pkg::ST_FULL;
                     state_in  = S_RESP;
                  end else begin
                     state_in = S_SEARCH;
                  end
               end else begin
                  state_in = S_RESP;
               end
            end
         end

         S_RESP: begin
            pend_in = 1'b0;
            if (rsp_if.ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_if.ready         = (state_ff == S_IDLE);
   assign rsp_if.valid         = (state_ff == S_RESP);
   assign rsp_if.status        = status_ff;
   assign rsp_if.found_payload = found_ff;
   assign rsp_if.fill_level    = 5'(used_ff);

endmodule

// File: rtl/keyed_table_with_compaction.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_table_with_compaction: unique-key table with lazy delete
// Top level: slot storage plus the command sequencer.
// ----------------------------------------------------------------------------
// Usage
//   req_if carries one command (insert, lookup, delete, compact) with a key
//   and a payload; rsp_if returns one result per command: status, the
//   payload found by a lookup, and the fill level after the command.
//   One command is in flight at a time; req_if.ready is high only while the
//   block is idle.
//   A search walks the used slots at one slot per cycle through the
//   registered read port of the slot memory. An insert into a full table
//   runs a compaction walk first; a compact command runs only that walk.
//   A new command is taken only after the response to the last one has
//   transferred.
//   Reset clears every busy mark and the fill count; slot contents are not
//   cleared and are only read below the fill position.
//   If the receiver stalls, the response holds on rsp_if and no new request
//   is taken until it transfers.
// ----------------------------------------------------------------------------
module keyed_table_with_compaction (
   input  logic       clock,
   input  logic       reset,
   ktc_req_if.sink    req_if,
   ktc_rsp_if.source  rsp_if
);

   ktc_pkg::mem_req_type                mem_req;
   logic [31:0]                         rd_key;
   logic [ktc_pkg::PAYLOAD_BITS-1:0]    rd_payload;

   ktc_slot_mem u_mem (
      .clock      (clock),
      .mem_req    (mem_req),
      .rd_key     (rd_key),
      .rd_payload (rd_payload)
   );

   ktc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .rsp_if     (rsp_if),
      .mem_req    (mem_req),
      .rd_key     (rd_key),
      .rd_payload (rd_payload)
   );

   // one command at a time: never ready while a response is pending
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_if.ready && rsp_if.valid))
      else $error("request taken while a response is pending");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("ready stayed high after a request transfer");

   a_found_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.status != ktc_pkg::ST_OK) |-> (rsp_if.found_payload == '0))
      else $error("payload returned on a failed command");

   a_full_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.status == ktc_pkg::ST_FULL)
         |-> (rsp_if.fill_level == 5'(ktc_pkg::ENTRIES)))
      else $error("table full reported below capacity");

endmodule
